>>> rtl/core/lrpg_pkg.sv
// ============================================================================
// LED ring pattern generator - shared definitions
// Widths, register indexes, pattern codes and the control/status bundles
// that join the controller to the datapath.
// ============================================================================
`default_nettype none

package lrpg_pkg;

    // Field widths
    localparam int TICK_W   = 32;
    localparam int COL_W    = 8;
    localparam int PIX_W    = 4;
    localparam int SPAN_W   = 5;
    localparam int PAT_W    = 3;
    localparam int DIVR_W   = 8;
    localparam int RLEN_W   = 5;
    localparam int CFG_W    = 8;
    localparam int CFGI_W   = 3;
    localparam int CD_W     = 12;

    // Serial divider: 32-bit dividend, 8-bit divisor
    localparam int DIVD_W   = 32;
    localparam int DIVS_W   = 8;

    localparam int MAX_LEDS_DEF = 16;

    localparam logic [CD_W-1:0] TIMEOUT_RELOAD = CD_W'(100 * 30);

    // Register indexes
    localparam logic [CFGI_W-1:0] REG_PATTERN   = 3'd0;
    localparam logic [CFGI_W-1:0] REG_RED       = 3'd1;
    localparam logic [CFGI_W-1:0] REG_GREEN     = 3'd2;
    localparam logic [CFGI_W-1:0] REG_BLUE      = 3'd3;
    localparam logic [CFGI_W-1:0] REG_SPAN      = 3'd4;
    localparam logic [CFGI_W-1:0] REG_DIVIDER   = 3'd5;
    localparam logic [CFGI_W-1:0] REG_TIMEOUT   = 3'd6;
    localparam logic [CFGI_W-1:0] REG_RING_LEN  = 3'd7;

    // Pattern codes
    localparam logic [PAT_W-1:0] PAT_TAIL  = 3'd1;
    localparam logic [PAT_W-1:0] PAT_CROSS = 3'd2;
    localparam logic [PAT_W-1:0] PAT_CLOCK = 3'd3;
    localparam logic [PAT_W-1:0] PAT_RIDER = 3'd4;
    localparam logic [PAT_W-1:0] PAT_BLINK = 3'd5;
    localparam logic [PAT_W-1:0] PAT_SOLID = 3'd6;

    // Division jobs run on the shared serial divider
    typedef enum logic [2:0] {
        JOB_TICK  = 3'd0,   // |tick| / |divider|
        JOB_MOD   = 3'd1,   // |q| / ring length
        JOB_TURN  = 3'd2,   // |q / len| / ring length
        JOB_RED   = 3'd3,   // red / span
        JOB_GREEN = 3'd4,   // green / span
        JOB_BLUE  = 3'd5    // blue / span
    } div_job_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_job_t div_job;
        logic     q_store;
        logic     prep;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     clr_we;
        logic     draw_we;
        logic     emit_rd;
        logic     out_load;
    } lrpg_cmd_t;

    typedef struct packed {
        logic blank_now;
        logic blank_frame;
        logic q_match;
        logic need_rgb;
        logic div_done;
        logic cnt_last;
        logic cnt_at_n;
        logic out_taken;
    } lrpg_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lrpg_div.sv
// ============================================================================
// LED ring pattern generator - serial divider
// Restoring unsigned divider, one quotient bit per cycle. done pulses in the
// cycle after the last step; quotient and remainder hold until next start.
// ============================================================================
`default_nettype none

module lrpg_div
    import lrpg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient,
    output logic [DIVS_W-1:0]      remainder
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;

    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   diff;
    logic              fits;

    // trial subtract
    assign shifted = {rem_reg, dvd_reg[DIVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/lrpg_ctrl.sv
// ============================================================================
// LED ring pattern generator - controller
// Sequences accept, divisions, frame clear, pattern draw and pixel emit.
// ============================================================================
`default_nettype none

module lrpg_ctrl
    import lrpg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire lrpg_stat_t stat,
    output lrpg_cmd_t       cmd
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_DIVQ = 14'b00000000000010,
        ST_CMP  = 14'b00000000000100,
        ST_DIVM = 14'b00000000001000,
        ST_DIVW = 14'b00000000010000,
        ST_DIVR = 14'b00000000100000,
        ST_DIVG = 14'b00000001000000,
        ST_DIVB = 14'b00000010000000,
        ST_PREP = 14'b00000100000000,
        ST_CLR  = 14'b00001000000000,
        ST_DRAW = 14'b00010000000000,
        ST_EMRD = 14'b00100000000000,
        ST_EMLD = 14'b01000000000000,
        ST_EMWT = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_job = JOB_TICK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.blank_now)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_CLR;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_job   = JOB_TICK;
                        state_next    = ST_DIVQ;
                    end
                end
            end
            ST_DIVQ:
            begin
                if (stat.div_done)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.q_match)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.q_store   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_job   = JOB_MOD;
                    state_next    = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_job   = JOB_TURN;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (stat.need_rgb)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_job   = JOB_RED;
                        state_next    = ST_DIVR;
                    end
                    else
                        state_next = ST_PREP;
                end
            end
            ST_DIVR:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_job   = JOB_GREEN;
                    state_next    = ST_DIVG;
                end
            end
            ST_DIVG:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_job   = JOB_BLUE;
                    state_next    = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                if (stat.div_done)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep    = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next  = ST_CLR;
            end
            ST_CLR:
            begin
                cmd.clr_we = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = stat.blank_frame ? ST_EMRD : ST_DRAW;
                end
                else
                    cmd.cnt_inc = 1'b1;
            end
            ST_DRAW:
            begin
                if (stat.cnt_at_n)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_EMRD;
                end
                else
                begin
                    cmd.draw_we = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_EMRD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMLD;
            end
            ST_EMLD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_EMWT;
            end
            ST_EMWT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.cnt_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_EMRD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lrpg_dp.sv
// ============================================================================
// LED ring pattern generator - datapath
// Config registers, countdown, quotient tracking, serial divider, frame
// buffer, pattern stepping and the output register.
// ============================================================================
`default_nettype none

module lrpg_dp
    import lrpg_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [CFGI_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic [TICK_W-1:0] frame_index,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [PIX_W-1:0]       pixel_index,
    output logic [COL_W-1:0]       red_out,
    output logic [COL_W-1:0]       green_out,
    output logic [COL_W-1:0]       blue_out,
    output logic                   last,
    input  wire lrpg_cmd_t         cmd,
    output lrpg_stat_t             stat
);

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int LEN_W = $clog2(MAX_LEDS + 1);
    localparam int CNT_W = (LEN_W > SPAN_W) ? LEN_W : SPAN_W;
    localparam int PIXD_W = 3 * COL_W;

    // configuration
    logic [PAT_W-1:0]  pattern_reg;
    logic [COL_W-1:0]  red_reg;
    logic [COL_W-1:0]  green_reg;
    logic [COL_W-1:0]  blue_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [DIVR_W-1:0] divider_reg;
    logic              tmo_en_reg;
    logic [RLEN_W-1:0] ring_len_reg;
    logic [CD_W-1:0]   cd_reg;

    logic              tmo_en_new;

    // frame state
    logic [TICK_W-1:0] q_reg;
    logic [TICK_W-1:0] prev_q_reg;
    logic              tick_neg_reg;
    logic              blank_reg;
    div_job_t          job_reg;
    logic [IDX_W-1:0]  m1_reg;
    logic              way_neg_reg;
    logic [COL_W-1:0]  rq_reg, gq_reg, bq_reg;
    logic [SPAN_W-1:0] rr_reg, gr_reg, br_reg;

    // draw state
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic              step_neg_reg;
    logic [SPAN_W-1:0] gap_cnt_reg;
    logic [COL_W:0]    ra_q_reg, ga_q_reg, ba_q_reg;
    logic [SPAN_W-1:0] ra_r_reg, ga_r_reg, ba_r_reg;

    // buffer and output
    logic [PIXD_W-1:0] fb_mem [MAX_LEDS];
    logic [PIXD_W-1:0] rd_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]  r_out_reg, g_out_reg, b_out_reg;
    logic              last_reg;

    // derived values
    logic [LEN_W-1:0]  len;
    logic              div_neg;
    logic [DIVR_W-1:0] mag;
    logic [DIVD_W-1:0] div_dvd;
    logic [DIVS_W-1:0] div_dvs;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVS_W-1:0] div_rem;
    logic [TICK_W-1:0] tick_mag;
    logic [TICK_W-1:0] q_mag;
    logic [TICK_W-1:0] q_new;
    logic [IDX_W-1:0]  m2;
    logic [LEN_W-1:0]  turn_mod;
    logic              cnt_last;
    logic              q_neg;
    logic              pd_neg;
    logic              pw_neg;
    logic [IDX_W-1:0]  pos_dir;
    logic [IDX_W-1:0]  pos_way;
    logic [IDX_W-1:0]  pos_step;
    logic [IDX_W-1:0]  draw_addr;
    logic [PIXD_W-1:0] draw_data;
    logic [SPAN_W-1:0] gap;
    logic [SPAN_W:0]   gap_inc;
    logic              blink_on;

    // ring length clamped to 1..MAX_LEDS
    always_comb
    begin
        if (ring_len_reg == '0)
            len = LEN_W'(1);
        else if (32'(ring_len_reg) > 32'(MAX_LEDS))
            len = LEN_W'(MAX_LEDS);
        else
            len = LEN_W'(ring_len_reg);
    end

    assign div_neg = divider_reg[DIVR_W-1];

    // divider magnitude, zero counts as one
    always_comb
    begin
        if (divider_reg == '0)
            mag = DIVR_W'(1);
        else if (div_neg)
            mag = -divider_reg;
        else
            mag = divider_reg;
    end

    // config writes and countdown
    assign tmo_en_new = (cfg_index == REG_TIMEOUT) ? cfg_data[0] : tmo_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            red_reg      <= '0;
            green_reg    <= '0;
            blue_reg     <= '0;
            span_reg     <= '0;
            divider_reg  <= DIVR_W'(1);
            tmo_en_reg   <= 1'b0;
            ring_len_reg <= RLEN_W'(16);
            cd_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN:  pattern_reg  <= cfg_data[PAT_W-1:0];
                REG_RED:      red_reg      <= cfg_data;
                REG_GREEN:    green_reg    <= cfg_data;
                REG_BLUE:     blue_reg     <= cfg_data;
                REG_SPAN:     span_reg     <= cfg_data[SPAN_W-1:0];
                REG_DIVIDER:  divider_reg  <= cfg_data;
                REG_TIMEOUT:  tmo_en_reg   <= cfg_data[0];
                REG_RING_LEN: ring_len_reg <= cfg_data[RLEN_W-1:0];
                default:      pattern_reg  <= pattern_reg;
            endcase
            if (tmo_en_new)
                cd_reg <= TIMEOUT_RELOAD;
        end
        else if (cmd.accept && tmo_en_reg && (cd_reg != '0))
            cd_reg <= cd_reg - CD_W'(1);
    end

    // shared serial divider
    assign tick_mag = frame_index[TICK_W-1] ? -frame_index : frame_index;
    assign q_mag    = q_reg[TICK_W-1] ? -q_reg : q_reg;

    always_comb
    begin
        unique case (cmd.div_job)
            JOB_TICK:  begin div_dvd = tick_mag;          div_dvs = mag;              end
            JOB_MOD:   begin div_dvd = q_mag;             div_dvs = DIVS_W'(len);     end
            JOB_TURN:  begin div_dvd = div_quo;           div_dvs = DIVS_W'(len);     end
            JOB_RED:   begin div_dvd = DIVD_W'(red_reg);   div_dvs = DIVS_W'(span_reg); end
            JOB_GREEN: begin div_dvd = DIVD_W'(green_reg); div_dvs = DIVS_W'(span_reg); end
            JOB_BLUE:  begin div_dvd = DIVD_W'(blue_reg);  div_dvs = DIVS_W'(span_reg); end
            default:   begin div_dvd = tick_mag;          div_dvs = mag;              end
        endcase
    end

    lrpg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // quotient sign and turn parity (floor mod of q/len over len)
    assign q_new    = tick_neg_reg ? -div_quo : div_quo;
    assign q_neg    = q_reg[TICK_W-1];
    assign m2       = IDX_W'(div_rem);
    assign turn_mod = (q_neg && (m2 != '0)) ? (len - LEN_W'(m2)) : LEN_W'(m2);

    // previous quotient, reset to minus one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_q_reg <= '1;
        else if (cmd.q_store)
            prev_q_reg <= q_reg;
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_reg <= 1'b0;
            job_reg   <= JOB_TICK;
        end
        else
        begin
            if (cmd.accept)
                blank_reg <= tmo_en_reg && (cd_reg == '0);
            if (cmd.div_start)
                job_reg <= cmd.div_job;
        end
    end

    // capture division results
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            tick_neg_reg <= frame_index[TICK_W-1];
        if (div_done)
        begin
            unique case (job_reg)
                JOB_TICK:  q_reg <= q_new;
                JOB_MOD:   m1_reg <= IDX_W'(div_rem);
                JOB_TURN:  way_neg_reg <= turn_mod[0] ^ div_neg;
                JOB_RED:   begin rq_reg <= COL_W'(div_quo); rr_reg <= SPAN_W'(div_rem); end
                JOB_GREEN: begin gq_reg <= COL_W'(div_quo); gr_reg <= SPAN_W'(div_rem); end
                JOB_BLUE:  begin bq_reg <= COL_W'(div_quo); br_reg <= SPAN_W'(div_rem); end
                default:   q_reg <= q_reg;
            endcase
        end
    end

    // start positions: floor mod of q*dir and q*way over len
    assign pd_neg  = q_neg ^ div_neg;
    assign pw_neg  = q_neg ^ way_neg_reg;
    assign pos_dir = (pd_neg && (m1_reg != '0)) ? IDX_W'(len - LEN_W'(m1_reg)) : m1_reg;
    assign pos_way = (pw_neg && (m1_reg != '0)) ? IDX_W'(len - LEN_W'(m1_reg)) : m1_reg;

    // next ring position
    always_comb
    begin
        if (step_neg_reg)
            pos_step = (pos_reg == '0) ? IDX_W'(len - LEN_W'(1)) : pos_reg - IDX_W'(1);
        else
            pos_step = (pos_reg == IDX_W'(len - LEN_W'(1))) ? '0 : pos_reg + IDX_W'(1);
    end

    assign gap      = (span_reg == '0) ? SPAN_W'(1) : span_reg;
    assign gap_inc  = {1'b0, gap_cnt_reg} + (SPAN_W+1)'(1);
    assign blink_on = q_reg[0] ^ div_neg;

    // pixel written by the pattern
    always_comb
    begin
        draw_addr = cnt_reg[IDX_W-1:0];
        draw_data = '0;
        unique case (pattern_reg)
            PAT_TAIL:
            begin
                draw_addr = pos_reg;
                draw_data = {ra_q_reg[COL_W-1:0], ga_q_reg[COL_W-1:0], ba_q_reg[COL_W-1:0]};
            end
            PAT_CROSS:
            begin
                draw_addr = pos_reg;
                draw_data = (gap_cnt_reg == '0) ? {red_reg, green_reg, blue_reg} : '0;
            end
            PAT_RIDER:
            begin
                draw_addr = pos_reg;
                draw_data = {red_reg, green_reg, blue_reg};
            end
            PAT_BLINK:
                draw_data = blink_on ? {red_reg, green_reg, blue_reg} : '0;
            PAT_CLOCK, PAT_SOLID:
                draw_data = {red_reg, green_reg, blue_reg};
            default:
                draw_data = '0;
        endcase
    end

    // draw setup and per-pixel stepping
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            pos_reg      <= (pattern_reg == PAT_RIDER) ? pos_way : pos_dir;
            step_neg_reg <= (pattern_reg == PAT_RIDER) ? way_neg_reg : div_neg;
            gap_cnt_reg  <= '0;
            ra_q_reg     <= '0;
            ga_q_reg     <= '0;
            ba_q_reg     <= '0;
            ra_r_reg     <= '0;
            ga_r_reg     <= '0;
            ba_r_reg     <= '0;
            unique case (pattern_reg)
                PAT_TAIL, PAT_RIDER:            n_reg <= CNT_W'(span_reg);
                PAT_CROSS, PAT_BLINK, PAT_SOLID: n_reg <= CNT_W'(len);
                PAT_CLOCK:                      n_reg <= CNT_W'(pos_dir);
                default:                        n_reg <= '0;
            endcase
        end
        else if (cmd.draw_we)
        begin
            pos_reg     <= pos_step;
            gap_cnt_reg <= (gap_inc == (SPAN_W+1)'(gap)) ? '0 : gap_inc[SPAN_W-1:0];
            // running color*x/span as quotient and remainder
            if (({1'b0, ra_r_reg} + {1'b0, rr_reg}) >= {1'b0, span_reg})
            begin
                ra_r_reg <= ra_r_reg + rr_reg - span_reg;
                ra_q_reg <= ra_q_reg + (COL_W+1)'(rq_reg) + (COL_W+1)'(1);
            end
            else
            begin
                ra_r_reg <= ra_r_reg + rr_reg;
                ra_q_reg <= ra_q_reg + (COL_W+1)'(rq_reg);
            end
            if (({1'b0, ga_r_reg} + {1'b0, gr_reg}) >= {1'b0, span_reg})
            begin
                ga_r_reg <= ga_r_reg + gr_reg - span_reg;
                ga_q_reg <= ga_q_reg + (COL_W+1)'(gq_reg) + (COL_W+1)'(1);
            end
            else
            begin
                ga_r_reg <= ga_r_reg + gr_reg;
                ga_q_reg <= ga_q_reg + (COL_W+1)'(gq_reg);
            end
            if (({1'b0, ba_r_reg} + {1'b0, br_reg}) >= {1'b0, span_reg})
            begin
                ba_r_reg <= ba_r_reg + br_reg - span_reg;
                ba_q_reg <= ba_q_reg + (COL_W+1)'(bq_reg) + (COL_W+1)'(1);
            end
            else
            begin
                ba_r_reg <= ba_r_reg + br_reg;
                ba_q_reg <= ba_q_reg + (COL_W+1)'(bq_reg);
            end
        end
    end

    // shared sweep counter for clear, draw and emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.cnt_inc)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    assign cnt_last = (cnt_reg == CNT_W'(len - LEN_W'(1)));

    // frame buffer
    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
            fb_mem[cnt_reg[IDX_W-1:0]] <= '0;
        else if (cmd.draw_we)
            fb_mem[draw_addr] <= draw_data;
        if (cmd.emit_rd)
            rd_reg <= fb_mem[cnt_reg[IDX_W-1:0]];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pix_reg   <= PIX_W'(cnt_reg);
            r_out_reg <= rd_reg[3*COL_W-1:2*COL_W];
            g_out_reg <= rd_reg[2*COL_W-1:COL_W];
            b_out_reg <= rd_reg[COL_W-1:0];
            last_reg  <= cnt_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pix_reg;
    assign red_out     = r_out_reg;
    assign green_out   = g_out_reg;
    assign blue_out    = b_out_reg;
    assign last        = last_reg;

    // status to controller
    always_comb
    begin
        stat             = '0;
        stat.blank_now   = tmo_en_reg && (cd_reg == '0);
        stat.blank_frame = blank_reg;
        stat.q_match     = (q_reg == prev_q_reg);
        stat.need_rgb    = (pattern_reg == PAT_TAIL) && (span_reg != '0);
        stat.div_done    = div_done;
        stat.cnt_last    = cnt_last;
        stat.cnt_at_n    = (cnt_reg == n_reg);
        stat.out_taken   = out_valid_reg && !out_stall;
    end

endmodule

`default_nettype wire

>>> rtl/core/led_ring_pattern_generator.sv
// Sequence: tick divide, compare, position and turn divides [and color divides for the
//   tail pattern with a nonzero span], prep, clear, draw, then for each pixel a buffer
//   read, output load and wait. A blanked tick goes from accept to clear and emit, no draw.
// Flow: one tick at a time; in_stall stays high from accept until the last pixel is taken.
//   A repeated quotient ends after the compare with no pixels. The 32-step divider sets the pace.
// Reset: asynchronous, sets config registers and countdown to defaults and previous quotient to minus one.
// ============================================================================
// LED ring pattern generator - top level
// Turns frame ticks into ring colors for one of several animated patterns.
// ============================================================================
`default_nettype none

module led_ring_pattern_generator
    import lrpg_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [CFGI_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [TICK_W-1:0] frame_index,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [PIX_W-1:0]       pixel_index,
    output logic [COL_W-1:0]       red_out,
    output logic [COL_W-1:0]       green_out,
    output logic [COL_W-1:0]       blue_out,
    output logic                   last
);

    lrpg_cmd_t  cmd;
    lrpg_stat_t stat;

    lrpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrpg_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .frame_index (frame_index),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_index (pixel_index),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

>>> rtl/core/lrpg_checker.sv
// ============================================================================
// LED ring pattern generator - port checker
// Watches the top-level ports for handshake and sequencing slips.
// ============================================================================
`default_nettype none

module lrpg_checker
    import lrpg_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [PIX_W-1:0] pixel_index,
    input wire logic [COL_W-1:0] red_out,
    input wire logic [COL_W-1:0] green_out,
    input wire logic [COL_W-1:0] blue_out,
    input wire logic             last
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(red_out)
            && $stable(green_out) && $stable(blue_out) && $stable(last))
        else $error("stalled output changed");

    // no new tick taken while a pixel is pending
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input ready while emitting");

    // an accepted tick keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("back-to-back tick accepted");

    // each pixel needs a buffer read before the next is shown
    a_pixel_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("output valid right after transaction");

endmodule

bind led_ring_pattern_generator lrpg_checker u_lrpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .last        (last)
);

`default_nettype wire

>>> tb/sv/led_ring_pattern_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED ring pattern generator testbench
// Drives frame ticks through every pattern and register setting, predicts
// each emitted pixel in a scoreboard and compares the pixel stream in order.
// ----------------------------------------------------------------------------

module led_ring_pattern_generator_tb;
    import lrpg_pkg::*;

    localparam int RING_MAX   = 16;
    localparam int WDOG_LIMIT = 20000;
    localparam int SETTLE     = 600;
    localparam int RELOAD     = 100 * 30;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] r;
        logic [COL_W-1:0] g;
        logic [COL_W-1:0] b;
        logic             fin;
    } pixel_t;

    // Scoreboard: ring model plus the queue of pixels still owed
    class pixel_scoreboard;
        pixel_t      expected_pixels[$];
        int          errors = 0;
        int unsigned pat, red, green, blue, span, tmo_en, ring_len;
        int          div;
        longint      prev_q;
        int unsigned countdown;
        logic [23:0] fb[RING_MAX];

        function new();
            pat = 0; red = 0; green = 0; blue = 0; span = 0;
            div = 1; tmo_en = 0; ring_len = 16;
            prev_q = -1; countdown = 0;
        endfunction

        function void write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_PATTERN:  pat = d[2:0];
                REG_RED:      red = d;
                REG_GREEN:    green = d;
                REG_BLUE:     blue = d;
                REG_SPAN:     span = d[4:0];
                REG_DIVIDER:  div = int'($signed(d));
                REG_TIMEOUT:  tmo_en = d[0];
                REG_RING_LEN: ring_len = d[4:0];
                default: ;
            endcase
            if (tmo_en != 0)
                countdown = RELOAD;
        endfunction

        function longint wrap(longint a, longint len);
            longint m;
            m = a % len;
            if (m < 0)
                m += len;
            return m;
        endfunction

        function void put(longint pos, longint r, longint g, longint b);
            fb[pos] = {r[7:0], g[7:0], b[7:0]};
        endfunction

        function void push_frame(longint len);
            pixel_t p;
            for (int k = 0; k < len; k++)
            begin
                p.pix = k[3:0];
                p.r   = fb[k][23:16];
                p.g   = fb[k][15:8];
                p.b   = fb[k][7:0];
                p.fin = (k == len - 1);
                expected_pixels.push_back(p);
            end
        endfunction

        // Work out the frame caused by one accepted tick
        function void predict_frame(logic [TICK_W-1:0] t);
            longint len, tk, mag, dir, q, s, gap, fill, way, x;
            int unsigned on;
            len = (ring_len == 0) ? 1 : (ring_len > RING_MAX) ? RING_MAX : ring_len;
            tk  = longint'($signed(t));
            mag = (div < 0) ? -div : div;
            dir = (div < 0) ? -1 : 1;
            s   = span;
            for (int k = 0; k < RING_MAX; k++)
                fb[k] = '0;
            if (tmo_en != 0)
            begin
                if (countdown == 0)
                begin
                    push_frame(len);
                    return;
                end
                countdown = (countdown - 1) & 12'hFFF;
            end
            if (mag == 0)
                mag = 1;
            q = tk / mag;
            if (q == prev_q)
                return;
            prev_q = q;
            case (pat)
                PAT_TAIL:
                    for (x = 0; x < s; x++)
                        put(wrap((q + x) * dir, len), red * x / s, green * x / s,
                            blue * x / s);
                PAT_CROSS:
                begin
                    gap = (s == 0) ? 1 : s;
                    for (x = 0; x < len; x++)
                        if (x % gap == 0)
                            put(wrap((q + x) * dir, len), red, green, blue);
                        else
                            put(wrap((q + x) * dir, len), 0, 0, 0);
                end
                PAT_CLOCK:
                begin
                    fill = wrap(q * dir, len);
                    for (x = 0; x < fill; x++)
                        put(x, red, green, blue);
                end
                PAT_RIDER:
                begin
                    way = (wrap(q / len, len) % 2 == 0) ? 1 : -1;
                    if (div < 0)
                        way = -way;
                    for (x = 0; x < s; x++)
                        put(wrap((q + x) * way, len), red, green, blue);
                end
                PAT_BLINK:
                begin
                    on = (q % 2 != 0) ? 1 : 0;
                    if (div < 0)
                        on ^= 1;
                    for (x = 0; x < len; x++)
                        put(x, red * on, green * on, blue * on);
                end
                PAT_SOLID:
                    for (x = 0; x < len; x++)
                        put(x, red, green, blue);
                default: ;
            endcase
            push_frame(len);
        endfunction

        function void check_pixel(pixel_t act);
            pixel_t e;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel %0d rgb %0h %0h %0h last %0b",
                         $time, act.pix, act.r, act.g, act.b, act.fin);
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            if (e.pix != act.pix)
                $display("%0t: pixel_index exp %0d act %0d", $time, e.pix, act.pix);
            if (e.r != act.r)
                $display("%0t: red_out exp %0h act %0h", $time, e.r, act.r);
            if (e.g != act.g)
                $display("%0t: green_out exp %0h act %0h", $time, e.g, act.g);
            if (e.b != act.b)
                $display("%0t: blue_out exp %0h act %0h", $time, e.b, act.b);
            if (e.fin != act.fin)
                $display("%0t: last exp %0b act %0b", $time, e.fin, act.fin);
            if (e.pix != act.pix || e.r != act.r || e.g != act.g || e.b != act.b ||
                e.fin != act.fin)
                errors++;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [CFGI_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [TICK_W-1:0] frame_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PIX_W-1:0]  pixel_index;
    logic [COL_W-1:0]  red_out;
    logic [COL_W-1:0]  green_out;
    logic [COL_W-1:0]  blue_out;
    logic              last;

    pixel_scoreboard sb = new();
    int in_idle_pct  = 0;
    int out_stall_pct = 0;
    int quiet_cycles = 0;

    led_ring_pattern_generator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .frame_index(frame_index),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_index(pixel_index),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output stall generator
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_pixel('{pixel_index, red_out, green_out, blue_out, last});
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("led_ring_pattern_generator regression: fail");
                $finish;
            end
        end
    end

    // Register write with junk above the register width
    task automatic write_reg(logic [CFGI_W-1:0] idx, int unsigned val);
        logic [CFG_W-1:0] mask;
        logic [CFG_W-1:0] d;
        case (idx)
            REG_PATTERN:  mask = 8'h07;
            REG_SPAN:     mask = 8'h1F;
            REG_TIMEOUT:  mask = 8'h01;
            REG_RING_LEN: mask = 8'h1F;
            default:      mask = 8'hFF;
        endcase
        d = (val[7:0] & mask) | (CFG_W'($urandom) & ~mask);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    task automatic configure(int unsigned pat, int unsigned r, int unsigned g,
                             int unsigned b, int unsigned sp, int dv,
                             int unsigned te, int unsigned rl);
        write_reg(REG_PATTERN, pat);
        write_reg(REG_RED, r);
        write_reg(REG_GREEN, g);
        write_reg(REG_BLUE, b);
        write_reg(REG_SPAN, sp);
        write_reg(REG_DIVIDER, dv);
        write_reg(REG_RING_LEN, rl);
        write_reg(REG_TIMEOUT, te);
        cfg_write <= 1'b0;
    endtask

    // Wait for every owed pixel, then let a dropped frame finish
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One tick transaction
    task automatic send_tick(logic [TICK_W-1:0] t);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < in_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        frame_index <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_frame(t);
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1: begin in_idle_pct = 56; out_stall_pct = 0;  end
            2: begin in_idle_pct = 0;  out_stall_pct = 56; end
            default: begin in_idle_pct = 31; out_stall_pct = 31; end
        endcase
    endtask

    initial
    begin
        logic [TICK_W-1:0] base;
        int unsigned pat;
        int dv;
        int unsigned sp, rl;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each pattern with extreme ticks and divider settings
        configure(PAT_TAIL, 255, 128, 1, 16, 1, 0, 16);
        send_tick(32'h8000_0000);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'hFFFF_FFFF);
        drain();
        configure(PAT_CROSS, 255, 255, 255, 0, -128, 0, 16);
        send_tick(32'h8000_0000);
        send_tick(32'd0);
        drain();
        configure(PAT_CROSS, 10, 20, 30, 3, 0, 0, 31);
        send_tick(32'd7);
        send_tick(32'd7);
        send_tick(32'hFFFF_FFF9);
        drain();
        configure(PAT_CLOCK, 1, 2, 3, 0, -1, 0, 0);
        send_tick(32'd5);
        drain();
        configure(PAT_CLOCK, 200, 0, 50, 0, -5, 0, 7);
        send_tick(32'hFFFF_FFEC);
        send_tick(32'd33);
        drain();
        configure(PAT_RIDER, 9, 8, 7, 0, 1, 0, 5);
        send_tick(32'd3);
        drain();
        configure(PAT_RIDER, 90, 80, 70, 31, 127, 0, 16);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h8000_0000);
        drain();
        configure(PAT_BLINK, 255, 0, 255, 4, -3, 0, 16);
        send_tick(32'd3);
        send_tick(32'd6);
        drain();
        configure(PAT_SOLID, 0, 255, 0, 0, 2, 0, 1);
        send_tick(32'd100);
        drain();
        configure(0, 255, 255, 255, 8, 1, 0, 16);
        send_tick(32'd1);
        drain();
        configure(7, 255, 255, 255, 8, 1, 0, 16);
        send_tick(32'd2);
        drain();

        // Countdown enabled: repeated ticks count it down
        configure(PAT_SOLID, 40, 50, 60, 0, 127, 1, 1);
        for (int i = 0; i < 10; i++)
            send_tick(32'd5);
        drain();

        // Random phases: ticks mostly stepping forward from a random base
        for (int ph = 0; ph < 12; ph++)
        begin
            pat = $urandom_range(7);
            case ($urandom_range(3))
                0: dv = -128;
                1: dv = 127;
                2: dv = $urandom_range(8) - 4;
                default: dv = int'($signed(8'($urandom)));
            endcase
            sp = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(16);
            rl = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
            configure(pat, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      sp, dv, $urandom_range(1), rl);
            set_idle(ph);
            base = ($urandom_range(1) == 0) ? $urandom : $urandom_range(2000);
            for (int i = 0; i < 40; i++)
            begin
                if (ph == 5 && i == 20)
                begin
                    // Hold off until the ring has caught up
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.expected_pixels.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(9) == 0)
                    send_tick($urandom);
                else
                begin
                    base = base + $urandom_range(3);
                    send_tick(base);
                end
            end
            drain();
        end

        set_idle(0);
        if (sb.errors == 0)
            $display("led_ring_pattern_generator regression: pass");
        else
            $display("led_ring_pattern_generator regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lrpg_pkg.sv
rtl/core/lrpg_div.sv
rtl/core/lrpg_ctrl.sv
rtl/core/lrpg_dp.sv
rtl/core/led_ring_pattern_generator.sv
rtl/core/lrpg_checker.sv
tb/sv/led_ring_pattern_generator_tb.sv
